FILE: src/bva_pkg.sv
// Shared constants and types for the battery voltage averager.
`timescale 1ns / 1ps
package bva_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int WINDOW      = 16;
  localparam int WIN_LOG2    = $clog2(WINDOW);
  localparam int SUM_BITS    = SAMPLE_BITS + WIN_LOG2;
  localparam int SCALE_BITS  = 18;
  localparam int Q_SHIFT     = 16;
  localparam int PROD_BITS   = SAMPLE_BITS + SCALE_BITS;
  localparam int MV_BITS     = PROD_BITS - Q_SHIFT;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 18'd102646;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [SCALE_BITS-1:0]  scale_t;
  typedef logic [MV_BITS-1:0]     mv_t;

  // Averaging stage handed to the scaling stage
  typedef struct packed {
    logic    valid;  // beat present
    logic    ok;     // window full and sample nonzero
    sample_t avg;    // truncated window average
  } avg_stage_t;

endpackage

FILE: src/bva_cell.sv
// One cell of the sample chain: holds one sample, passes it on when shifted.
`timescale 1ns / 1ps
module bva_cell
  import bva_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    shift,
  input  sample_t d,
  output sample_t q
);

  sample_t sample;

  // Empty cells read as zero until a sample arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (shift) begin
      sample <= d;
    end
  end

  assign q = sample;

endmodule

FILE: src/bva_scale.sv
// Scaling stage: average times Q16 scale, output register for the result beat.
`timescale 1ns / 1ps
module bva_scale
  import bva_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  avg_stage_t stage,
  input  scale_t     scale,
  input  logic       advance,
  output logic       out_valid,
  output mv_t        out_mv,
  output logic       out_ok
);

  logic [PROD_BITS-1:0] prod;
  mv_t                  mv_next;

  // Q16 product, truncated; zero when the result is not valid
  always_comb begin
    prod    = PROD_BITS'(stage.avg) * PROD_BITS'(scale);
    mv_next = stage.ok ? prod[PROD_BITS-1:Q_SHIFT] : '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mv <= mv_next;
      out_ok <= stage.ok;
    end
  end

endmodule

FILE: src/battery_voltage_averager.sv
// Top level: moving average of nonzero ADC samples scaled to millivolts.
// An accepted input beat passes the averaging stage and output registers.
// Throughput: one beat per cycle when m_tready allows; chain shift and sum
// update happen in the accept cycle, the multiply sits in the following stage.
// Reset (rst, synchronous): chain cells and running sum clear to zero,
// scale register returns to its default, no result beat pending.
`timescale 1ns / 1ps
module battery_voltage_averager
  import bva_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [17:0] cfg_wdata,    // scale_q16
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,      // [11:0] adc_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,      // [13:0] millivolts
  output logic        m_tuser       // [0] valid_res
);

  scale_t     scale;
  sum_t       running_sum;
  sum_t       sum_next;
  sample_t    sample_in;
  sample_t    chain_q [WINDOW];
  logic       accept;
  logic       shift;
  logic       out_free;
  avg_stage_t stage;
  avg_stage_t stage_next;
  mv_t        out_mv;

  // Scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_wdata;
    end
  end

  // Handshake: the pipeline moves whenever the output register can take a beat
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = !stage.valid || out_free;
  assign accept    = s_tvalid && s_tready;
  assign sample_in = s_tdata[SAMPLE_BITS-1:0];
  assign shift     = accept && (sample_in != '0);

  // Chain of cells: newest at the head, oldest leaves from the tail
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      bva_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (sample_in),
        .q     (chain_q[i])
      );
    end else begin : g_body
      bva_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (chain_q[i-1]),
        .q     (chain_q[i])
      );
    end
  end

  // Running sum and averaging stage
  always_comb begin
    sum_next         = running_sum - SUM_BITS'(chain_q[WINDOW-1]) + SUM_BITS'(sample_in);
    stage_next.valid = accept;
    stage_next.ok    = (sample_in != '0) && (chain_q[WINDOW-2] != '0);
    stage_next.avg   = sum_next[SUM_BITS-1:WIN_LOG2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (shift) begin
      running_sum <= sum_next;
    end
  end

  // Averaging stage register: only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (s_tready) begin
      stage.valid <= stage_next.valid;
    end
    if (s_tready) begin
      stage.ok  <= stage_next.ok;
      stage.avg <= stage_next.avg;
    end
  end

  // Multiply and output register
  bva_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .scale     (scale),
    .advance   (out_free),
    .out_valid (m_tvalid),
    .out_mv    (out_mv),
    .out_ok    (m_tuser)
  );

  assign m_tdata = {{(16 - MV_BITS){1'b0}}, out_mv};

  // A result flagged invalid carries zero millivolts
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("invalid result with nonzero millivolts");

  // Input only stalls behind a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

  // A zero sample leaves the running sum alone
  a_zero_keeps_sum: assert property (@(posedge clk) disable iff (rst)
    accept && sample_in == '0 |=> $stable(running_sum))
    else $error("running sum changed on zero sample");

endmodule
